@@ rtl/core/bfs_pkg.sv @@
// Package for the byte frequency sort block: payload structs, controller states,
// and the command and status structs that join controller and datapath. No dependencies.
package bfs_pkg;

  localparam int MAX_LEN_DEF      = 4096;
  localparam int SYMBOL_COUNT_DEF = 256;

  typedef struct packed {
    logic       mode;
    logic [7:0] symbol;
  } in_t;

  typedef struct packed {
    logic [7:0] out_symbol;
    logic       is_last;
    logic       empty_res;
    logic       overflowed;
  } out_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_LD_WR,
    ST_CHK,
    ST_SCAN,
    ST_EMIT,
    ST_EMPTY
  } state_t;

  typedef enum logic [1:0] {
    RD_OP,
    RD_CUR,
    RD_IDX
  } rd_src_t;

  typedef struct packed {
    logic    in_take;
    logic    rd_en;
    rd_src_t rd_src;
    logic    clr_wr;
    logic    ld_wr;
    logic    set_drop;
    logic    chk_take;
    logic    scan_start;
    logic    scan_step;
    logic    scan_take;
    logic    emit;
    logic    emit_empty;
  } cmd_t;

  typedef struct packed {
    logic op_mode;
    logic sym_ok;
    logic full;
    logic total_zero;
    logic cur_valid;
    logic cnt_nonzero;
    logic idx_end;
    logic scan_done;
    logic out_free;
  } stat_t;

endpackage

@@ rtl/core/bfs_ctrl.sv @@
// Controller state machine for the byte frequency sort block.
// Depends on bfs_pkg; drives the datapath by command struct only.
module bfs_ctrl import bfs_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_src = RD_OP;
    in_stall   = 1'b1;
    unique case (state)
      ST_CLEAR: begin
        if (stat.idx_end) begin
          state_next = ST_IDLE;
        end else begin
          cmd.clr_wr    = 1'b1;
          cmd.scan_step = 1'b1;
        end
      end
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.in_take = in_valid;
        if (in_valid) state_next = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        if (!stat.op_mode) begin
          state_next = ST_IDLE;
          if (stat.sym_ok && !stat.full) begin
            cmd.rd_en  = 1'b1;
            cmd.rd_src = RD_OP;
            state_next = ST_LD_WR;
          end else if (stat.sym_ok) begin
            cmd.set_drop = 1'b1;
          end
        end else if (stat.total_zero) begin
          state_next = ST_EMPTY;
        end else if (stat.cur_valid) begin
          // Keep emitting the current value while copies remain.
          cmd.rd_en  = 1'b1;
          cmd.rd_src = RD_CUR;
          state_next = ST_CHK;
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = ST_SCAN;
        end
      end
      ST_LD_WR: begin
        cmd.ld_wr  = 1'b1;
        state_next = ST_IDLE;
      end
      ST_CHK: begin
        if (stat.cnt_nonzero) begin
          cmd.chk_take = 1'b1;
          state_next   = ST_EMIT;
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!stat.idx_end) begin
          cmd.rd_en     = 1'b1;
          cmd.rd_src    = RD_IDX;
          cmd.scan_step = 1'b1;
        end
        if (stat.scan_done) begin
          cmd.scan_take = 1'b1;
          state_next    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_EMPTY: begin
        if (stat.out_free) begin
          cmd.emit_empty = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

endmodule

@@ rtl/core/bfs_dp.sv @@
// Datapath for the byte frequency sort block: count memory, totals, scan for the
// largest bin, and the output register. Depends on bfs_pkg.
module bfs_dp import bfs_pkg::*; #(
  parameter int MAX_LEN      = MAX_LEN_DEF,
  parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  in_t   in_data,
  input  cmd_t  cmd,
  output stat_t stat,
  output logic  out_valid,
  input  logic  out_stall,
  output out_t  out_data
);

  localparam int AW = $clog2(SYMBOL_COUNT);
  localparam int IW = $clog2(SYMBOL_COUNT + 1);
  localparam int CW = $clog2(MAX_LEN + 1);

  logic [CW-1:0] bin_mem [SYMBOL_COUNT];

  logic          op_mode;
  logic [7:0]    op_sym;
  logic [CW-1:0] total;
  logic          drop;
  logic          cur_valid;
  logic [AW-1:0] cur_sym;
  logic [CW-1:0] cur_cnt;
  logic [IW-1:0] idx;
  logic [CW-1:0] best_cnt;
  logic [AW-1:0] best_sym;
  logic [CW-1:0] rd_data;
  logic [AW-1:0] rd_tag;
  logic          rd_pend;
  logic [AW-1:0] rd_addr;

  always_comb begin
    unique case (cmd.rd_src)
      RD_OP:   rd_addr = op_sym[AW-1:0];
      RD_CUR:  rd_addr = cur_sym;
      RD_IDX:  rd_addr = idx[AW-1:0];
      default: rd_addr = op_sym[AW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) rd_data <= bin_mem[rd_addr];
    if (cmd.clr_wr) begin
      bin_mem[idx[AW-1:0]] <= '0;
    end else if (cmd.ld_wr) begin
      bin_mem[op_sym[AW-1:0]] <= rd_data + CW'(1);
    end else if (cmd.emit) begin
      bin_mem[cur_sym] <= cur_cnt - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    rd_tag <= rd_addr;
    if (cmd.in_take) begin
      op_mode <= in_data.mode;
      op_sym  <= in_data.symbol;
    end
    if (cmd.chk_take) cur_cnt <= rd_data;
    if (cmd.scan_take) begin
      cur_sym <= best_sym;
      cur_cnt <= best_cnt;
    end
    // A strict compare keeps the lower value on equal counts.
    if (cmd.scan_start) begin
      best_cnt <= '0;
      best_sym <= '0;
    end else if (rd_pend && (rd_data > best_cnt)) begin
      best_cnt <= rd_data;
      best_sym <= rd_tag;
    end
    if (cmd.emit) begin
      out_data.out_symbol <= 8'(cur_sym);
      out_data.is_last    <= (total == CW'(1));
      out_data.empty_res  <= 1'b0;
      out_data.overflowed <= drop;
    end else if (cmd.emit_empty) begin
      out_data.out_symbol <= '0;
      out_data.is_last    <= 1'b0;
      out_data.empty_res  <= 1'b1;
      out_data.overflowed <= drop;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total     <= '0;
      drop      <= 1'b0;
      cur_valid <= 1'b0;
      idx       <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_pend <= cmd.rd_en && (cmd.rd_src == RD_IDX);
      if (cmd.set_drop) drop <= 1'b1;
      if (cmd.scan_start) begin
        idx <= '0;
      end else if (cmd.scan_step) begin
        idx <= idx + IW'(1);
      end
      if (cmd.ld_wr) begin
        total     <= total + CW'(1);
        cur_valid <= 1'b0;
      end else if (cmd.emit) begin
        total     <= total - CW'(1);
        cur_valid <= (total != CW'(1));
      end else if (cmd.scan_take) begin
        cur_valid <= 1'b1;
      end
      if (cmd.emit || cmd.emit_empty) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    stat.op_mode     = op_mode;
    stat.sym_ok      = ({1'b0, op_sym} < 9'(SYMBOL_COUNT));
    stat.full        = (total == CW'(MAX_LEN));
    stat.total_zero  = (total == '0);
    stat.cur_valid   = cur_valid;
    stat.cnt_nonzero = (rd_data != '0);
    stat.idx_end     = (idx == IW'(SYMBOL_COUNT));
    stat.scan_done   = stat.idx_end && !rd_pend;
    stat.out_free    = !out_valid || !out_stall;
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit || cmd.emit_empty) |-> (!out_valid || !out_stall))
    else $error("result produced while the output register is still held");
  a_best_found: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_take |-> (best_cnt != '0))
    else $error("scan finished without a bin holding any copies");
  a_total_cap: assert property (@(posedge clk) disable iff (rst)
    cmd.ld_wr |=> (total <= CW'(MAX_LEN)) && (total != '0))
    else $error("byte count outside its range after a load");

endmodule

@@ rtl/core/byte_frequency_sort_top.sv @@
// Top level of the byte frequency sort block: joins bfs_ctrl and bfs_dp.
// Depends on bfs_pkg.
//
// Items with mode 0 load a byte into a histogram; items with mode 1 each pull one
// result, the bytes regrouped by decreasing count with ties to the lower value.
// After reset a clearing pass runs through the count memory before the first item is
// taken; a new item is taken only once the last one is through. A load reads the count
// of its byte and writes it back one higher. A pull that continues the current value
// rereads its count, an empty pull gives an empty result, and a pull that must choose a
// new value scans the count memory through its single read port.
// A result waits in an output register, so loads carry on while it is held.
module byte_frequency_sort_top import bfs_pkg::*; #(
  parameter int MAX_LEN      = MAX_LEN_DEF,
  parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  cmd_t  cmd;
  stat_t stat;

  bfs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  bfs_dp #(
    .MAX_LEN      (MAX_LEN),
    .SYMBOL_COUNT (SYMBOL_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for byte_frequency_sort_top: random loads and pulls, each pull
// checked against a behavioural histogram kept here. Depends on bfs_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
  import bfs_pkg::*;

  localparam int MAX_BYTES = MAX_LEN_DEF;
  localparam int ALPHABET  = SYMBOL_COUNT_DEF;
  localparam int CYCLE_LIMIT = 1500000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  byte_frequency_sort_top dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Histogram predictor state.
  int unsigned hist_count[ALPHABET];
  byte unsigned rank_order[ALPHABET];
  bit ranked;
  int unsigned rank_pos;
  int unsigned bytes_held;
  bit dropped;

  in_t  pending_items[$];
  out_t sorted_bytes[$];
  int   errors = 0;
  int   pulls_seen = 0;
  int   cycles = 0;
  bit   stimulus_done = 0;

  task automatic rank_histogram();
    int unsigned j;
    byte unsigned v;
    for (int i = 0; i < ALPHABET; i++) begin
      v = i[7:0];
      j = i;
      while (j > 0 && hist_count[rank_order[j-1]] < hist_count[v]) begin
        rank_order[j] = rank_order[j-1];
        j--;
      end
      rank_order[j] = v;
    end
    rank_pos = 0;
    ranked = 1;
  endtask

  task automatic predict_sorted(input in_t item);
    out_t r;
    byte unsigned v;
    r = '0;
    if (item.mode == 1'b0) begin
      if (item.symbol >= ALPHABET) return;
      if (bytes_held >= MAX_BYTES) begin
        dropped = 1;
        return;
      end
      hist_count[item.symbol]++;
      bytes_held++;
      ranked = 0;
      rank_pos = 0;
      return;
    end
    r.overflowed = dropped;
    if (bytes_held == 0) begin
      r.empty_res = 1'b1;
      sorted_bytes.push_back(r);
      return;
    end
    if (!ranked) rank_histogram();
    while (rank_pos < ALPHABET && hist_count[rank_order[rank_pos]] == 0) rank_pos++;
    v = rank_order[rank_pos];
    hist_count[v]--;
    bytes_held--;
    r.out_symbol = v;
    r.is_last = (bytes_held == 0);
    if (bytes_held == 0) begin
      ranked = 0;
      rank_pos = 0;
    end
    sorted_bytes.push_back(r);
  endtask

  // Driver: holds a payload until its transfer, then waits a drawn gap.
  int in_gap = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        predict_sorted(in_data);
        void'(pending_items.pop_front());
        in_valid <= 1'b0;
        in_gap <= $urandom_range(0, 3);
      end else if (!in_valid) begin
        if (in_gap > 0) in_gap <= in_gap - 1;
        else if (pending_items.size() > 0) begin
          in_data <= pending_items[0];
          in_valid <= 1'b1;
        end
      end
    end
  end

  // Monitor: compares each result transfer with the oldest prediction.
  int out_hold = 0;
  always @(posedge clk) begin
    out_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        pulls_seen <= pulls_seen + 1;
        if (sorted_bytes.size() == 0) begin
          $error("unexpected result %h", out_data);
          errors = errors + 1;
        end else begin
          want = sorted_bytes.pop_front();
          if (want.out_symbol !== out_data.out_symbol) begin
            $error("out_symbol expected %0d actual %0d", want.out_symbol, out_data.out_symbol);
            errors = errors + 1;
          end
          if (want.is_last !== out_data.is_last) begin
            $error("is_last expected %0d actual %0d", want.is_last, out_data.is_last);
            errors = errors + 1;
          end
          if (want.empty_res !== out_data.empty_res) begin
            $error("empty_res expected %0d actual %0d", want.empty_res, out_data.empty_res);
            errors = errors + 1;
          end
          if (want.overflowed !== out_data.overflowed) begin
            $error("overflowed expected %0d actual %0d", want.overflowed, out_data.overflowed);
            errors = errors + 1;
          end
        end
      end
      // Stall for a drawn number of cycles per result, with quiet stretches.
      if (out_hold > 0) begin
        out_stall <= 1'b1;
        out_hold <= out_hold - 1;
      end else begin
        out_stall <= 1'b0;
        if (out_valid && !out_stall)
          out_hold <= ((cycles / 2000) % 3 == 0) ? 0 : $urandom_range(0, 3);
      end
    end
  end

  function automatic in_t make_item(bit m, byte unsigned s);
    in_t it;
    it.mode = m;
    it.symbol = s;
    return it;
  endfunction

  task automatic add_string(int len, int spread);
    int base;
    base = $urandom_range(0, 255);
    for (int i = 0; i < len; i++) begin
      if (spread == 0) pending_items.push_back(make_item(1'b0, 8'($urandom_range(0, 255))));
      else pending_items.push_back(
        make_item(1'b0, 8'((base + $urandom_range(0, spread)) % 256)));
    end
  endtask

  task automatic add_pulls(int n);
    for (int i = 0; i < n; i++) pending_items.push_back(make_item(1'b1, 8'd0));
  endtask

  initial begin
    int len;
    // Directed: empty pull, extreme symbols, ties, all-ones/zeros patterns.
    add_pulls(1);
    pending_items.push_back(make_item(1'b0, 8'd255));
    pending_items.push_back(make_item(1'b0, 8'd0));
    pending_items.push_back(make_item(1'b0, 8'd255));
    pending_items.push_back(make_item(1'b0, 8'd170));
    pending_items.push_back(make_item(1'b0, 8'd85));
    add_pulls(2);
    // A load during emission restarts the ordering.
    pending_items.push_back(make_item(1'b0, 8'd85));
    pending_items.push_back(make_item(1'b0, 8'd85));
    add_pulls(5);
    add_pulls(1);
    // Random strings, each mostly drained, sometimes interleaved.
    while (pending_items.size() < 1370) begin
      len = $urandom_range(1, 20);
      add_string(len, ($urandom_range(0, 1) != 0) ? 255 : 4);
      if ($urandom_range(0, 4) == 0) add_string($urandom_range(1, 3), 7);
      add_pulls(len + $urandom_range(0, 4) - 2);
    end
    // Drain what is left, ending with empty pulls.
    add_pulls(30);
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    wait (pending_items.size() == 0);
    wait (sorted_bytes.size() == 0);
    repeat (600) @(posedge clk);
    stimulus_done = 1;
    $display("Transfers of loads and pulls done; %0d pulled results checked, including",
             pulls_seen);
    $display("empty pulls, ties, reloads during emission and output stalls.");
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    if (!stimulus_done) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

endmodule
